/* src/mapstep_pkg.sv */
`timescale 1ns / 1ps

package mapstep_pkg;

    // Walk step magnitude at or below this counts as not walking
    localparam logic [32:0] WALK_TOLERANCE = 33'd0;

    localparam int ADDR_W    = 5;
    localparam int S_TDATA_W = 232;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    typedef enum logic [2:0] {
        REG_WALK_SINGLE = 3'd0,
        REG_WALK_DOUBLE = 3'd1,
        REG_MOB_SINGLE  = 3'd2,
        REG_MOB_DOUBLE  = 3'd3,
        REG_KICK_SINGLE = 3'd4,
        REG_KICK_DOUBLE = 3'd5,
        REG_INV_STALL   = 3'd6,
        REG_MODE        = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_MOVED       = 3'd0,
        ST_PAUSE_MINUS = 3'd1,
        ST_PAUSE_PLUS  = 3'd2,
        ST_OFF_MINUS   = 3'd3,
        ST_OFF_PLUS    = 3'd4,
        ST_STILL       = 3'd5
    } status_t;

    localparam logic [1:0] BS_SINGLE = 2'd1;
    localparam logic [1:0] BS_DOUBLE = 2'd2;

    localparam logic [1:0] DIR_PLUS  = 2'd1;
    localparam logic [1:0] DIR_MINUS = 2'd2;

    localparam int MODE_PAUSE_MINUS = 0;
    localparam int MODE_PAUSE_PLUS  = 1;
    localparam int MODE_FORCE_DEP   = 2;

    typedef struct packed {
        logic [31:0] walk_step_single;
        logic [31:0] walk_step_double;
        logic [30:0] mobility_step_single;
        logic [30:0] mobility_step_double;
        logic [30:0] kick_single;
        logic [30:0] kick_double;
        logic [30:0] inverse_stall_force;
        logic [4:0]  mode_bits;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  bind_state;
        logic        held;
        logic        active_flip;
        logic [31:0] track_position;
        logic [30:0] track_length;
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic [31:0] force_z;
        logic [17:0] axis_x;
        logic [17:0] axis_y;
        logic [17:0] axis_z;
        logic [15:0] normal_noise;
    } in_item_t;

    typedef struct packed {
        logic [31:0] new_position;
        status_t     step_status;
    } out_item_t;

endpackage

/* src/mapstep_pipe.sv */
`timescale 1ns / 1ps

module mapstep_pipe
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mapstep_pkg::cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mapstep_pkg::in_item_t  in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mapstep_pkg::out_item_t out_item
);

    // per-item control carried down the pipe
    typedef struct packed {
        logic        still;
        logic        walker;
        logic        diffuse;
        logic        dir_pos;
        logic        dir_neg;
        logic [30:0] len;
        logic [31:0] pos;
        logic [31:0] ws;
        logic [30:0] mob;
    } ctl_t;

    // valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic adv1, adv2, adv3, adv4, adv5, advo;

    assign advo     = !vo_reg || out_ready;
    assign adv5     = !v5_reg || advo;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (advo) vo_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: select, decode, products ----------------
    logic signed [31:0] ws_sel;
    logic        [30:0] mob_sel;
    logic        [30:0] kick_sel;
    logic        [32:0] ws_mag;
    logic               bound;
    logic               dir_p0, dir_n0;
    ctl_t               ctl1_next;
    logic signed [49:0] px_next, py_next, pz_next;
    logic signed [46:0] kp_next;

    always_comb
    begin
        case (in_item.bind_state)
            mapstep_pkg::BS_SINGLE:
            begin
                ws_sel   = $signed(cfg.walk_step_single);
                mob_sel  = cfg.mobility_step_single;
                kick_sel = cfg.kick_single;
                bound    = 1'b1;
            end
            mapstep_pkg::BS_DOUBLE:
            begin
                ws_sel   = $signed(cfg.walk_step_double);
                mob_sel  = cfg.mobility_step_double;
                kick_sel = cfg.kick_double;
                bound    = 1'b1;
            end
            default:
            begin
                ws_sel   = 32'sd0;
                mob_sel  = 31'd0;
                kick_sel = 31'd0;
                bound    = 1'b0;
            end
        endcase

        ws_mag = ws_sel[31] ? (33'd0 - {ws_sel[31], ws_sel}) : {ws_sel[31], ws_sel};

        dir_p0 = (cfg.mode_bits[4:3] == mapstep_pkg::DIR_PLUS);
        dir_n0 = (cfg.mode_bits[4:3] == mapstep_pkg::DIR_MINUS);

        ctl1_next.walker  = ws_mag > mapstep_pkg::WALK_TOLERANCE;
        ctl1_next.diffuse = |mob_sel;
        ctl1_next.still   = !bound || in_item.held
                            || (!ctl1_next.diffuse && !ctl1_next.walker);
        ctl1_next.dir_pos = in_item.active_flip ? dir_n0 : dir_p0;
        ctl1_next.dir_neg = in_item.active_flip ? dir_p0 : dir_n0;
        ctl1_next.len     = in_item.track_length;
        ctl1_next.pos     = in_item.track_position;
        ctl1_next.ws      = ws_sel;
        ctl1_next.mob     = mob_sel;

        px_next = 50'($signed(in_item.force_x)) * 50'($signed(in_item.axis_x));
        py_next = 50'($signed(in_item.force_y)) * 50'($signed(in_item.axis_y));
        pz_next = 50'($signed(in_item.force_z)) * 50'($signed(in_item.axis_z));
        kp_next = 47'($signed({1'b0, kick_sel})) * 47'($signed(in_item.normal_noise));
    end

    ctl_t               ctl1_reg;
    logic signed [49:0] px_reg, py_reg, pz_reg;
    logic signed [46:0] kp_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            ctl1_reg <= ctl1_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
            kp_reg   <= kp_next;
        end
    end

    // ---------------- stage 2: axial force, thermal kick ----------------
    logic signed [51:0] dot;
    logic signed [35:0] proj_w;
    logic signed [31:0] proj_next;
    logic signed [34:0] kick_term;
    logic signed [35:0] posk_next;

    always_comb
    begin
        dot    = 52'(px_reg) + 52'(py_reg) + 52'(pz_reg);
        proj_w = 36'(dot >>> 16);
        if (proj_w[35:31] != {5{proj_w[35]}})
            proj_next = proj_w[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            proj_next = proj_w[31:0];
        kick_term = 35'(kp_reg >>> 12);
        if (ctl1_reg.diffuse)
            posk_next = 36'($signed(ctl1_reg.pos)) + 36'(kick_term);
        else
            posk_next = 36'($signed(ctl1_reg.pos));
    end

    ctl_t               ctl2_reg;
    logic signed [31:0] proj_reg;
    logic signed [35:0] posk2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            ctl2_reg  <= ctl1_reg;
            proj_reg  <= proj_next;
            posk2_reg <= posk_next;
        end
    end

    // ---------------- stage 3: drift and stall products ----------------
    logic signed [62:0] drift_p_next, fac_p_next;

    always_comb
    begin
        drift_p_next = 63'($signed({1'b0, ctl2_reg.mob})) * 63'(proj_reg);
        fac_p_next   = 63'($signed({1'b0, cfg.inverse_stall_force})) * 63'(proj_reg);
    end

    ctl_t               ctl3_reg;
    logic signed [62:0] drift_p_reg, fac_p_reg;
    logic signed [35:0] posk3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            ctl3_reg    <= ctl2_reg;
            drift_p_reg <= drift_p_next;
            fac_p_reg   <= fac_p_next;
            posk3_reg   <= posk2_reg;
        end
    end

    // ---------------- stage 4: first end check, force factor ----------------
    logic                   fdep;
    logic signed [46:0]     drift;
    logic signed [47:0]     pos_d;
    logic signed [47:0]     len_d;
    logic signed [62:0]     fac_q;
    logic signed [47:0]     fsum;
    logic        [31:0]     pos4_next;
    mapstep_pkg::status_t   st4_next;
    logic                   off4_next;
    logic        [16:0]     factor_next;

    always_comb
    begin
        fdep  = cfg.mode_bits[mapstep_pkg::MODE_FORCE_DEP];
        drift = 47'(drift_p_reg >>> 16);
        pos_d = 48'(posk3_reg);
        if (fdep && !ctl3_reg.walker)
            pos_d = pos_d + 48'(drift);
        len_d = $signed({17'd0, ctl3_reg.len});

        off4_next = 1'b0;
        st4_next  = mapstep_pkg::ST_MOVED;
        pos4_next = ctl3_reg.pos;
        if (ctl3_reg.diffuse)
        begin
            if (pos_d < 48'sd0)
            begin
                pos4_next = 32'd0;
                if (cfg.mode_bits[mapstep_pkg::MODE_PAUSE_MINUS])
                    st4_next = mapstep_pkg::ST_PAUSE_MINUS;
                else
                begin
                    st4_next  = mapstep_pkg::ST_OFF_MINUS;
                    off4_next = 1'b1;
                end
            end
            else if (pos_d > len_d)
            begin
                if (cfg.mode_bits[mapstep_pkg::MODE_PAUSE_PLUS])
                begin
                    pos4_next = {1'b0, ctl3_reg.len};
                    st4_next  = mapstep_pkg::ST_PAUSE_PLUS;
                end
                else
                begin
                    pos4_next = 32'd0;
                    st4_next  = mapstep_pkg::ST_OFF_PLUS;
                    off4_next = 1'b1;
                end
            end
            else
                pos4_next = pos_d[31:0];
        end

        // sign applied before the floor shift
        if (ctl3_reg.dir_neg)
            fac_q = -fac_p_reg;
        else if (ctl3_reg.dir_pos)
            fac_q = fac_p_reg;
        else
            fac_q = 63'sd0;
        fsum = 48'(fac_q >>> 16) + 48'sd65536;
        if (!fdep)
            factor_next = 17'd65536;
        else if (fsum < 48'sd0)
            factor_next = 17'd0;
        else if (fsum > 48'sd65536)
            factor_next = 17'd65536;
        else
            factor_next = fsum[16:0];
    end

    ctl_t                 ctl4_reg;
    logic        [31:0]   pos4_reg;
    mapstep_pkg::status_t st4_reg;
    logic                 off4_reg;
    logic        [16:0]   factor_reg;

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            ctl4_reg   <= ctl3_reg;
            pos4_reg   <= pos4_next;
            st4_reg    <= st4_next;
            off4_reg   <= off4_next;
            factor_reg <= factor_next;
        end
    end

    // ---------------- stage 5: walk product ----------------
    logic signed [48:0] walk_p_next;

    assign walk_p_next = 49'($signed(ctl4_reg.ws)) * 49'($signed({1'b0, factor_reg}));

    ctl_t                 ctl5_reg;
    logic        [31:0]   pos5_reg;
    mapstep_pkg::status_t st5_reg;
    logic                 off5_reg;
    logic signed [48:0]   walk_p_reg;

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            ctl5_reg   <= ctl4_reg;
            pos5_reg   <= pos4_reg;
            st5_reg    <= st4_reg;
            off5_reg   <= off4_reg;
            walk_p_reg <= walk_p_next;
        end
    end

    // ---------------- stage 6: walk, second end check ----------------
    logic signed [32:0]     walk;
    logic signed [33:0]     wstep;
    logic signed [34:0]     pos_w;
    logic signed [34:0]     len_w;
    mapstep_pkg::out_item_t out_next;

    always_comb
    begin
        walk = 33'(walk_p_reg >>> 16);
        if (ctl5_reg.dir_pos)
            wstep = 34'(walk);
        else if (ctl5_reg.dir_neg)
            wstep = -34'(walk);
        else
            wstep = 34'sd0;
        pos_w = 35'($signed(pos5_reg)) + 35'(wstep);
        len_w = $signed({4'd0, ctl5_reg.len});

        if (ctl5_reg.still)
        begin
            out_next.new_position = ctl5_reg.pos;
            out_next.step_status  = mapstep_pkg::ST_STILL;
        end
        else if (off5_reg || !ctl5_reg.walker)
        begin
            out_next.new_position = pos5_reg;
            out_next.step_status  = st5_reg;
        end
        else if (pos_w < 35'sd0)
        begin
            out_next.new_position = 32'd0;
            out_next.step_status  = cfg.mode_bits[mapstep_pkg::MODE_PAUSE_MINUS]
                                    ? mapstep_pkg::ST_PAUSE_MINUS
                                    : mapstep_pkg::ST_OFF_MINUS;
        end
        else if (pos_w > len_w)
        begin
            if (cfg.mode_bits[mapstep_pkg::MODE_PAUSE_PLUS])
            begin
                out_next.new_position = {1'b0, ctl5_reg.len};
                out_next.step_status  = mapstep_pkg::ST_PAUSE_PLUS;
            end
            else
            begin
                out_next.new_position = 32'd0;
                out_next.step_status  = mapstep_pkg::ST_OFF_PLUS;
            end
        end
        else
        begin
            out_next.new_position = pos_w[31:0];
            out_next.step_status  = mapstep_pkg::ST_MOVED;
        end
    end

    mapstep_pkg::out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (advo)
            out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

/* src/motor_anchor_position_step_top.sv */
`timescale 1ns / 1ps

// Motor anchor position step. Each input beat describes one anchor (bind state
// and flags on s_tuser, position, track length, force, track axis and a normal
// noise sample on s_tdata); each produces exactly one output beat with the new
// position (Q16.16) and a step status. The datapath is a six-stage pipeline:
// one beat is taken every clock unless back-pressure has filled the pipe, and
// each beat moves down the stages in order; the depth is set by the chain of
// multipliers (axial force, drift and stall products, then the walk product),
// each followed by a register. Back-pressure on m_tready only holds stages that
// are occupied, so bubbles are squeezed out and s_tready stays high whenever the
// output register is empty. The eight registers are written over the APB port
// at byte address 4*index and must only be changed while no beat is in flight.
// All registers reset to zero.

module motor_anchor_position_step_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mapstep_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, low bit up: track_position[31:0], track_length[62:32],
    // force_x[94:63], force_y[126:95], force_z[158:127], axis_x[176:159],
    // axis_y[194:177], axis_z[212:195], normal_noise[228:213], zero pad
    input  logic [mapstep_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser, low bit up: bind_state[1:0], held[2], active_flip[3]
    input  logic [mapstep_pkg::S_TUSER_W-1:0]   s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: new_position[31:0]
    output logic [mapstep_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: step_status[2:0]
    output logic [mapstep_pkg::M_TUSER_W-1:0]   m_tuser
);

    mapstep_pkg::cfg_t       cfg_reg;
    mapstep_pkg::cfg_t       cfg_next;
    mapstep_pkg::reg_index_t reg_idx;
    logic                    wr_en;
    mapstep_pkg::in_item_t   in_item;
    mapstep_pkg::out_item_t  out_item;

    assign pready  = 1'b1;
    assign reg_idx = mapstep_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // register write: field truncated to its width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                mapstep_pkg::REG_WALK_SINGLE: cfg_next.walk_step_single     = pwdata;
                mapstep_pkg::REG_WALK_DOUBLE: cfg_next.walk_step_double     = pwdata;
                mapstep_pkg::REG_MOB_SINGLE:  cfg_next.mobility_step_single = pwdata[30:0];
                mapstep_pkg::REG_MOB_DOUBLE:  cfg_next.mobility_step_double = pwdata[30:0];
                mapstep_pkg::REG_KICK_SINGLE: cfg_next.kick_single          = pwdata[30:0];
                mapstep_pkg::REG_KICK_DOUBLE: cfg_next.kick_double          = pwdata[30:0];
                mapstep_pkg::REG_INV_STALL:   cfg_next.inverse_stall_force  = pwdata[30:0];
                mapstep_pkg::REG_MODE:        cfg_next.mode_bits            = pwdata[4:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // readback, zero extended
    always_comb
    begin
        case (reg_idx)
            mapstep_pkg::REG_WALK_SINGLE: prdata = cfg_reg.walk_step_single;
            mapstep_pkg::REG_WALK_DOUBLE: prdata = cfg_reg.walk_step_double;
            mapstep_pkg::REG_MOB_SINGLE:  prdata = {1'b0, cfg_reg.mobility_step_single};
            mapstep_pkg::REG_MOB_DOUBLE:  prdata = {1'b0, cfg_reg.mobility_step_double};
            mapstep_pkg::REG_KICK_SINGLE: prdata = {1'b0, cfg_reg.kick_single};
            mapstep_pkg::REG_KICK_DOUBLE: prdata = {1'b0, cfg_reg.kick_double};
            mapstep_pkg::REG_INV_STALL:   prdata = {1'b0, cfg_reg.inverse_stall_force};
            mapstep_pkg::REG_MODE:        prdata = {27'd0, cfg_reg.mode_bits};
            default:                      prdata = 32'd0;
        endcase
    end

    // unpack the input beat
    assign in_item.bind_state     = s_tuser[1:0];
    assign in_item.held           = s_tuser[2];
    assign in_item.active_flip    = s_tuser[3];
    assign in_item.track_position = s_tdata[31:0];
    assign in_item.track_length   = s_tdata[62:32];
    assign in_item.force_x        = s_tdata[94:63];
    assign in_item.force_y        = s_tdata[126:95];
    assign in_item.force_z        = s_tdata[158:127];
    assign in_item.axis_x         = s_tdata[176:159];
    assign in_item.axis_y         = s_tdata[194:177];
    assign in_item.axis_z         = s_tdata[212:195];
    assign in_item.normal_noise   = s_tdata[228:213];

    mapstep_pipe u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item.new_position;
    assign m_tuser = out_item.step_status;

endmodule

/* src/mapstep_checker.sv */
`timescale 1ns / 1ps

module mapstep_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mapstep_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mapstep_pkg::M_TUSER_W-1:0] m_tuser
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed under stall");

    // anchor that fell off, or paused at the minus end, sits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == mapstep_pkg::ST_OFF_MINUS
                     || m_tuser == mapstep_pkg::ST_OFF_PLUS
                     || m_tuser == mapstep_pkg::ST_PAUSE_MINUS) |-> m_tdata == 32'd0)
        else $error("end status with non-zero position");

    // after an end check that kept the anchor it is not below the track start
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == mapstep_pkg::ST_MOVED
                     || m_tuser == mapstep_pkg::ST_PAUSE_PLUS) |-> !m_tdata[31])
        else $error("kept anchor below track start");

    // status code in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= mapstep_pkg::ST_STILL)
        else $error("step status out of range");

    // empty output register means nothing can hold the pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output register empty");

endmodule

bind motor_anchor_position_step_top mapstep_checker u_mapstep_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb_motor_anchor_position_step_top.sv */
`timescale 1ns / 1ps

// Testbench for the motor anchor position step.
// Anchor beats go in on the s_ stream, one result beat per anchor comes back on
// the m_ stream. Every accepted anchor is run through a local model of the
// step: diffusion kick, force drift for non-walkers, end check, force-scaled
// walk, second end check. The result lands in a FIFO of predicted positions,
// and the checker pops it against each result beat.
// Registers are only rewritten once the FIFO is empty and the pipe has had
// time to drain.

module tb_motor_anchor_position_step_top;

    import mapstep_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PIPE_DEPTH   = 6;
    localparam int SWEEP_PHASES = 8;
    localparam int SWEEP_BEATS  = 190;
    localparam int PRESS_BEATS  = 160;
    localparam int PRESS_HOLD   = 300;
    localparam int MAX_REPORTS  = 10;

    // bind states that count as unbound
    localparam logic [1:0] BS_NONE  = 2'd0;
    localparam logic [1:0] BS_THREE = 2'd3;
    // direction codes with no stepping
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_VOID = 2'd3;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // shadow of the register file, updated once the whole set has been written
    cfg_t      cur_cfg = '0;
    // predicted position/status per accepted anchor, oldest first
    out_item_t predicted_q[$];
    out_item_t want;

    bit tx_gaps      = 1'b1;
    bit rx_stalls    = 1'b1;
    int hold_request = 0;

    int n_sent      = 0;
    int n_checked   = 0;
    int n_err       = 0;
    int n_cfg       = 0;
    int n_in_stall  = 0;
    int cycles      = 0;
    int status_seen[6];

    motor_anchor_position_step_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Step model
    // ------------------------------------------------------------------

    function automatic status_t track_end_status(input longint p, input longint l,
                                                 input logic [4:0] m);
        if (p < 0)
        begin
            if (m[MODE_PAUSE_MINUS])
                return ST_PAUSE_MINUS;
            return ST_OFF_MINUS;
        end
        if (p > l)
        begin
            if (m[MODE_PAUSE_PLUS])
                return ST_PAUSE_PLUS;
            return ST_OFF_PLUS;
        end
        return ST_MOVED;
    endfunction

    function automatic out_item_t predict_step(input cfg_t c, input in_item_t a);
        longint     pos, len, dot, axial, stride, mob, kick, dirn, factor, mag, noise;
        longint     fx, fy, fz, ux, uy, uz;
        logic [1:0] dcode;
        bit         fdep, diffuse, walker;
        status_t    st;
        out_item_t  r;
        pos   = $signed(a.track_position);
        len   = a.track_length;
        fx    = $signed(a.force_x);
        fy    = $signed(a.force_y);
        fz    = $signed(a.force_z);
        ux    = $signed(a.axis_x);
        uy    = $signed(a.axis_y);
        uz    = $signed(a.axis_z);
        noise = $signed(a.normal_noise);

        // axial force, floored and saturated to 32 bits
        dot   = fx * ux + fy * uy + fz * uz;
        axial = dot >>> 16;
        if (axial > 64'sh7FFF_FFFF)
            axial = 64'sh7FFF_FFFF;
        if (axial < -64'sh8000_0000)
            axial = -64'sh8000_0000;

        stride = 0;
        mob    = 0;
        kick   = 0;
        if (a.bind_state == BS_SINGLE)
        begin
            stride = $signed(c.walk_step_single);
            mob    = c.mobility_step_single;
            kick   = c.kick_single;
        end
        else if (a.bind_state == BS_DOUBLE)
        begin
            stride = $signed(c.walk_step_double);
            mob    = c.mobility_step_double;
            kick   = c.kick_double;
        end

        dcode = c.mode_bits[4:3];
        dirn  = (dcode == DIR_PLUS) ? 1 : (dcode == DIR_MINUS) ? -1 : 0;
        if (a.active_flip)
            dirn = -dirn;
        fdep    = c.mode_bits[MODE_FORCE_DEP];
        mag     = (stride < 0) ? -stride : stride;
        diffuse = mob > 0;
        walker  = mag > longint'(WALK_TOLERANCE);

        r.new_position = a.track_position;
        r.step_status  = ST_STILL;
        if ((a.bind_state != BS_SINGLE && a.bind_state != BS_DOUBLE) || a.held
            || (!diffuse && !walker))
            return r;

        st = ST_MOVED;
        if (diffuse)
        begin
            pos += (kick * noise) >>> 12;
            if (fdep && !walker)
                pos += (mob * axial) >>> 16;
            st = track_end_status(pos, len, c.mode_bits);
            if (st == ST_PAUSE_MINUS)
                pos = 0;
            else if (st == ST_PAUSE_PLUS)
                pos = len;
        end
        if (walker && st != ST_OFF_MINUS && st != ST_OFF_PLUS)
        begin
            factor = 65536;
            if (fdep)
            begin
                factor = 65536 + ((dirn * axial * longint'(c.inverse_stall_force)) >>> 16);
                if (factor > 65536)
                    factor = 65536;
                if (factor < 0)
                    factor = 0;
            end
            pos += dirn * ((stride * factor) >>> 16);
            st = track_end_status(pos, len, c.mode_bits);
            if (st == ST_PAUSE_MINUS)
                pos = 0;
            else if (st == ST_PAUSE_PLUS)
                pos = len;
        end
        if (st == ST_OFF_MINUS || st == ST_OFF_PLUS)
            pos = 0;
        r.new_position = pos[31:0];
        r.step_status  = st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [4:0] mode_word(input logic [1:0] d, input bit fdep,
                                             input bit pause_plus, input bit pause_minus);
        logic [4:0] m;
        m                   = '0;
        m[4:3]              = d;
        m[MODE_FORCE_DEP]   = fdep;
        m[MODE_PAUSE_PLUS]  = pause_plus;
        m[MODE_PAUSE_MINUS] = pause_minus;
        return m;
    endfunction

    function automatic cfg_t make_cfg(input logic [31:0] ws1, input logic [31:0] ws2,
                                      input logic [30:0] mob1, input logic [30:0] mob2,
                                      input logic [30:0] k1, input logic [30:0] k2,
                                      input logic [30:0] inv, input logic [4:0] mode);
        cfg_t c;
        c.walk_step_single     = ws1;
        c.walk_step_double     = ws2;
        c.mobility_step_single = mob1;
        c.mobility_step_double = mob2;
        c.kick_single          = k1;
        c.kick_double          = k2;
        c.inverse_stall_force  = inv;
        c.mode_bits            = mode;
        return c;
    endfunction

    // anchor with no force and the track along +x
    function automatic in_item_t anchor_at(input logic [1:0] bs, input bit flip,
                                           input logic [31:0] pos, input logic [30:0] len,
                                           input logic [15:0] noise);
        in_item_t a;
        a                = '0;
        a.bind_state     = bs;
        a.active_flip    = flip;
        a.track_position = pos;
        a.track_length   = len;
        a.axis_x         = 18'h1_0000;
        a.normal_noise   = noise;
        return a;
    endfunction

    function automatic logic [31:0] rand_reg(input int bits, input bit can_neg);
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 32'd0;
        if (pick == 1)
            return (can_neg && $urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        v = $urandom >> (32 - bits);
        if (can_neg && $urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // scale sets the typical magnitude (in bits) of steps and track lengths
    function automatic cfg_t random_cfg(input int scale);
        cfg_t c;
        c.walk_step_single     = rand_reg(scale, 1'b1);
        c.walk_step_double     = rand_reg(scale, 1'b1);
        c.mobility_step_single = rand_reg($urandom_range(1, scale), 1'b0);
        c.mobility_step_double = rand_reg($urandom_range(1, scale), 1'b0);
        c.kick_single          = rand_reg(scale, 1'b0);
        c.kick_double          = rand_reg(scale, 1'b0);
        c.inverse_stall_force  = rand_reg($urandom_range(1, 31), 1'b0);
        c.mode_bits            = $urandom_range(0, 31);
        return c;
    endfunction

    function automatic logic [31:0] rand_force();
        return $signed($urandom) >>> $urandom_range(0, 24);
    endfunction

    function automatic in_item_t random_anchor(input int scale);
        in_item_t    a;
        int          len_bits, pick, u;
        logic [31:0] lenv;
        pick         = $urandom_range(0, 9);
        a.bind_state = (pick < 4) ? BS_SINGLE : (pick < 8) ? BS_DOUBLE :
                       (pick == 8) ? BS_NONE : BS_THREE;
        a.held        = ($urandom_range(0, 9) == 0);
        a.active_flip = $urandom_range(0, 1);
        // track length mostly near the step scale so the ends get hit
        len_bits = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 31)
                                               : scale + $urandom_range(0, 4);
        if (len_bits > 31)
            len_bits = 31;
        lenv           = $urandom >> (32 - len_bits);
        a.track_length = lenv[30:0];
        pick = $urandom_range(0, 9);
        if (pick == 0)
            a.track_position = $urandom;
        else if (pick == 1)
            a.track_position = '0;
        else if (pick == 2)
            a.track_position = lenv;
        else
            a.track_position = $urandom_range(0, lenv);
        a.force_x = rand_force();
        a.force_y = rand_force();
        a.force_z = rand_force();
        u = $urandom_range(0, 131072) - 65536;
        a.axis_x = u[17:0];
        u = $urandom_range(0, 131072) - 65536;
        a.axis_y = u[17:0];
        u = $urandom_range(0, 131072) - 65536;
        a.axis_z = u[17:0];
        a.normal_noise = $urandom;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain the pipe, then write the whole register set
    task automatic apply_config(input cfg_t c);
        s_tvalid <= 1'b0;
        while (predicted_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
        write_reg(REG_WALK_SINGLE, c.walk_step_single);
        write_reg(REG_WALK_DOUBLE, c.walk_step_double);
        write_reg(REG_MOB_SINGLE,  c.mobility_step_single);
        write_reg(REG_MOB_DOUBLE,  c.mobility_step_double);
        write_reg(REG_KICK_SINGLE, c.kick_single);
        write_reg(REG_KICK_DOUBLE, c.kick_double);
        write_reg(REG_INV_STALL,   c.inverse_stall_force);
        write_reg(REG_MODE,        c.mode_bits);
        cur_cfg = c;
        n_cfg++;
    endtask

    // Offer one anchor beat and hold it until taken. tvalid stays high on
    // return so back-to-back beats need no extra assignment.
    task automatic send_anchor(input in_item_t a);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, a.normal_noise, a.axis_z, a.axis_y, a.axis_x,
                     a.force_z, a.force_y, a.force_x, a.track_length, a.track_position};
        s_tuser  <= {a.active_flip, a.held, a.bind_state};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted_q.push_back(predict_step(cur_cfg, a));
        n_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // unbound, bind state three, held, and nothing to do
    task automatic test_no_motion();
        in_item_t a;
        apply_config(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0002_0000, 31'h0004_0000, 16'h1000));
        apply_config(make_cfg(32'h0001_0000, 32'hFFFE_0000, 31'h100, 0, 31'h800, 0, 0,
                              mode_word(DIR_PLUS, 1'b0, 1'b1, 1'b1)));
        send_anchor(anchor_at(BS_NONE, 1'b0, 32'h0002_0000, 31'h0004_0000, 16'h1000));
        send_anchor(anchor_at(BS_THREE, 1'b0, 32'h0002_0000, 31'h0004_0000, 16'h1000));
        a      = anchor_at(BS_SINGLE, 1'b0, 32'h0002_0000, 31'h0004_0000, 16'h1000);
        a.held = 1'b1;
        send_anchor(a);
        // walker only (negative step), then kick plus walk
        send_anchor(anchor_at(BS_DOUBLE, 1'b0, 32'h0003_0000, 31'h0004_0000, 16'h0));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0001_0000, 31'h0004_0000, 16'hF000));
    endtask

    // falling off and pausing at both ends, after kick and after walk
    task automatic test_track_ends();
        apply_config(make_cfg(32'h0003_0000, 32'h0003_0000, 0, 0, 0, 0, 0,
                              mode_word(DIR_PLUS, 1'b0, 1'b0, 1'b0)));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0004_0000, 31'h0005_0000, 16'h0));
        send_anchor(anchor_at(BS_SINGLE, 1'b1, 32'h0001_0000, 31'h0005_0000, 16'h0));
        apply_config(make_cfg(32'h0003_0000, 32'h0003_0000, 0, 0, 0, 0, 0,
                              mode_word(DIR_PLUS, 1'b0, 1'b1, 1'b1)));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0004_0000, 31'h0005_0000, 16'h0));
        send_anchor(anchor_at(BS_DOUBLE, 1'b1, 32'h0001_0000, 31'h0005_0000, 16'h0));
        // kick pauses at minus end, walk then brings it back inside: moved
        apply_config(make_cfg(32'h0002_0000, 0, 31'h1, 0, 31'h1_0000, 0, 0,
                              mode_word(DIR_PLUS, 1'b0, 1'b1, 1'b1)));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0001_0000, 31'h0005_0000, 16'hC000));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0006_0000, 31'h0005_0000, 16'h0));
        // kick alone takes it off before any walk
        apply_config(make_cfg(32'h0002_0000, 0, 31'h1, 0, 31'h1_0000, 0, 0,
                              mode_word(DIR_PLUS, 1'b0, 1'b0, 1'b0)));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0001_0000, 31'h0005_0000, 16'hC000));
        // direction code three: walker does not step
        apply_config(make_cfg(32'h0002_0000, 0, 31'h1, 0, 31'h1_0000, 0, 0,
                              mode_word(DIR_VOID, 1'b0, 1'b1, 1'b1)));
        send_anchor(anchor_at(BS_SINGLE, 1'b0, 32'h0002_0000, 31'h0005_0000, 16'h1000));
    endtask

    // stall factor in range and clamped either way, drift, zero reciprocal
    task automatic test_force_dependence();
        in_item_t a;
        apply_config(make_cfg(32'h0002_0000, 0, 0, 31'h8000, 0, 0, 31'h8000,
                              mode_word(DIR_PLUS, 1'b1, 1'b1, 1'b1)));
        a         = anchor_at(BS_SINGLE, 1'b0, 32'h0004_0000, 31'h0010_0000, 16'h0);
        a.force_x = 32'hFFFF_0000;
        send_anchor(a);
        a.force_x = 32'h0004_0000;
        send_anchor(a);
        a.force_x = 32'hFFFC_0000;
        send_anchor(a);
        a            = anchor_at(BS_DOUBLE, 1'b0, 32'h0004_0000, 31'h0010_0000, 16'h0);
        a.force_x    = 32'h0003_0000;
        send_anchor(a);
        apply_config(make_cfg(32'h0002_0000, 0, 0, 31'h8000, 0, 0, 0,
                              mode_word(DIR_PLUS, 1'b1, 1'b1, 1'b1)));
        a         = anchor_at(BS_SINGLE, 1'b0, 32'h0004_0000, 31'h0010_0000, 16'h0);
        a.force_x = 32'hFFFC_0000;
        send_anchor(a);
    endtask

    // full-scale registers and fields
    task automatic test_field_extremes();
        in_item_t a;
        apply_config(make_cfg(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              mode_word(DIR_MINUS, 1'b1, 1'b1, 1'b1)));
        a = anchor_at(BS_SINGLE, 1'b0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h7FFF);
        a.force_x = 32'h7FFF_FFFF;
        a.force_y = 32'h7FFF_FFFF;
        a.force_z = 32'h7FFF_FFFF;
        a.axis_y  = 18'h1_0000;
        a.axis_z  = 18'h1_0000;
        send_anchor(a);
        a = anchor_at(BS_DOUBLE, 1'b0, 32'h8000_0000, 31'h0, 16'h8000);
        a.force_x = 32'h8000_0000;
        a.force_y = 32'h8000_0000;
        a.force_z = 32'h8000_0000;
        a.axis_x  = 18'h3_0000;
        a.axis_y  = 18'h3_0000;
        a.axis_z  = 18'h3_0000;
        send_anchor(a);
        a = anchor_at(BS_SINGLE, 1'b1, 32'h0, 31'h7FFF_FFFF, 16'hFFFF);
        a.force_x = 32'h8000_0000;
        a.force_y = 32'h7FFF_FFFF;
        a.axis_y  = 18'h3_0000;
        send_anchor(a);
        apply_config(make_cfg(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              mode_word(DIR_PLUS, 1'b1, 1'b0, 1'b0)));
        a = anchor_at(BS_DOUBLE, 1'b0, 32'h4000_0000, 31'h7FFF_FFFF, 16'h0001);
        a.force_x = 32'h0001_0000;
        send_anchor(a);
        apply_config(make_cfg(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                              mode_word(DIR_VOID, 1'b1, 1'b1, 1'b1)));
        send_anchor(anchor_at(BS_SINGLE, 1'b1, 32'h0000_0001, 31'h0000_0002, 16'h0800));
    endtask

    // random settings per phase; idling re-drawn every few dozen beats
    task automatic test_random_sweep();
        int scale;
        for (int ph = 0; ph < SWEEP_PHASES; ph++)
        begin
            scale = $urandom_range(4, 28);
            apply_config(random_cfg(scale));
            for (int k = 0; k < SWEEP_BEATS; k++)
            begin
                if (k % 40 == 0)
                begin
                    tx_gaps   = ($urandom_range(0, 3) != 0);
                    rx_stalls = ($urandom_range(0, 3) != 0);
                end
                send_anchor(random_anchor(scale));
            end
        end
    endtask

    // sink holds off for a long stretch while the source streams flat out,
    // so the pipe fills and s_tready must drop
    task automatic test_output_backpressure();
        int scale;
        scale = $urandom_range(4, 28);
        apply_config(random_cfg(scale));
        tx_gaps      = 1'b0;
        rx_stalls    = 1'b1;
        hold_request = PRESS_HOLD;
        repeat (PRESS_BEATS) send_anchor(random_anchor(scale));
        tx_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sink ready: per-beat random stall, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : sink_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (m_tvalid && m_tready)
                stall_left = rx_stalls ? $urandom_range(0, 5) : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && !s_tready)
            n_in_stall++;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser < 6)
                status_seen[m_tuser]++;
            if (predicted_q.size() == 0)
            begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("unexpected result beat: position %h status %0d",
                             m_tdata, m_tuser);
            end
            else
            begin
                want = predicted_q.pop_front();
                if (m_tdata !== want.new_position || m_tuser !== want.step_status)
                begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("mismatch on result %0d: position exp %h got %h, status exp %0d got %0d",
                                 n_checked, want.new_position, m_tdata,
                                 want.step_status, m_tuser);
                end
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timed out after %0d cycles, %0d results outstanding",
                 cycles, predicted_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_motion();
        test_track_ends();
        test_force_dependence();
        test_field_extremes();
        test_random_sweep();
        test_output_backpressure();

        s_tvalid <= 1'b0;
        while (predicted_q.size() != 0)
            @(posedge clk);
        repeat (4 * PIPE_DEPTH) @(posedge clk);

        $display("%0d anchor beats under %0d register settings, %0d results checked, %0d input stall cycles",
                 n_sent, n_cfg, n_checked, n_in_stall);
        $display("statuses: moved %0d, paused -/+ %0d/%0d, off -/+ %0d/%0d, still %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
